[src/sn2d_pkg.sv]
`timescale 1ns / 1ps
package sn2d_pkg;

  // Table geometry
  localparam int PERM_ENTRIES = 256;
  localparam int PERM_AW      = 8;
  localparam int PERM_DW      = 8;

  // Field widths
  localparam int COORD_W              = 32;
  localparam int DEF_COORD_FRAC_BITS  = 16;
  localparam int NOISE_W              = 16;

  // Internal formats: corner offsets Q.24, gradient term, contributions Q.30
  localparam int INT_FRAC = 24;
  localparam int OFS_W    = 32;
  localparam int G_W      = 34;
  localparam int SUM_W    = 32;

  // Skew, unskew and output scale constants
  localparam logic signed [63:0]      F2_Q30     = 64'sd393016784;
  localparam logic signed [63:0]      G2_Q30     = 64'sd226908266;
  localparam logic signed [OFS_W-1:0] G2_Q24     = 32'sd3545442;
  localparam logic signed [OFS_W-1:0] G2X2_Q24   = 32'sd7090884;
  localparam logic signed [OFS_W-1:0] ONE_Q24    = 32'sd16777216;
  localparam logic signed [63:0]      HALF_Q48   = 64'sd140737488355328;
  localparam logic signed [63:0]      SCALE_Q20  = 64'sd47427774;
  localparam logic signed [63:0]      ONE_Q50    = 64'sd1125899906842624;
  localparam logic [NOISE_W-1:0]      NOISE_MAX  = 16'hFFFF;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [PERM_AW-1:0]        perm_index;
    logic [PERM_DW-1:0]        perm_value;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
  } item_t;

endpackage

[src/sn2d_ram.sv]
`timescale 1ns / 1ps
module sn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port, read data held while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/sn2d_front.sv]
`timescale 1ns / 1ps
module sn2d_front
  import sn2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic                      op,
  input  logic [PERM_AW-1:0]        perm_index,
  input  logic [PERM_DW-1:0]        perm_value,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  output logic                      head_vld,
  output item_t                     head,
  input  logic                      head_pop
);

  item_t       buf_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;
  item_t       item;

  // Classify the incoming beat
  always_comb begin
    item            = '0;
    item.op         = op ? OP_EVAL : OP_LOAD;
    item.perm_index = perm_index;
    item.perm_value = perm_value;
    item.x_coord    = x_coord;
    item.y_coord    = y_coord;
  end

  assign full     = (cnt_r == 2'd2);
  assign accept   = push && !full;
  assign head_vld = (cnt_r != 2'd0);
  assign head     = buf_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ accept;
    rd_ptr_nxt = rd_ptr_r ^ head_pop;
    cnt_nxt    = cnt_r + 2'(accept) - 2'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[wr_ptr_r] <= item;
    end
  end

endmodule

[src/sn2d_corner.sv]
`timescale 1ns / 1ps
module sn2d_corner
  import sn2d_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [OFS_W-1:0] dx_i,
  input  logic signed [OFS_W-1:0] dy_i,
  input  logic [PERM_DW-1:0]      hash_i,
  output logic                    vld_o,
  output logic signed [SUM_W-1:0] contrib_o
);

  logic [8:0]              vld_r;
  logic signed [63:0]      sqx_r, sqy_r;
  logic signed [G_W-1:0]   g_r [7];
  logic signed [63:0]      r_r;
  logic [29:0]             t1_r;
  logic [59:0]             p1_r;
  logic [28:0]             t2_r;
  logic [57:0]             p2_r;
  logic [26:0]             t3_r;
  logic signed [63:0]      p3_r;
  logic signed [SUM_W-1:0] contrib_r;

  logic [5:0]              h;
  logic signed [OFS_W-1:0] u, v;
  logic signed [G_W-1:0]   u_e, v2, g_nxt;
  logic signed [63:0]      t1_rnd;
  logic [59:0]             p1_rnd;
  logic [57:0]             p2_rnd;
  logic signed [63:0]      p3_rnd;

  // Gradient dot product from the selector bits
  always_comb begin
    h     = hash_i[5:0];
    u     = (h < 6'd4) ? dx_i : dy_i;
    v     = (h < 6'd4) ? dy_i : dx_i;
    u_e   = G_W'(u);
    v2    = G_W'(v) <<< 1;
    g_nxt = (h[0] ? -u_e : u_e) + (h[1] ? -v2 : v2);
  end

  // Rounding of the falloff chain
  always_comb begin
    t1_rnd = (r_r + 64'sd131072) >>> 18;
    p1_rnd = (p1_r + 60'd536870912) >> 30;
    p2_rnd = (p2_r + 58'd536870912) >> 30;
    p3_rnd = (p3_r + 64'sd8388608) >>> 24;
  end

  // Valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], vld_i};
    end
  end

  // Falloff (0.5 - d^2)^4 times gradient; the two squares share the first stage, later stages hold at most one multiply
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= 64'(dx_i) * 64'(dx_i);
      sqy_r  <= 64'(dy_i) * 64'(dy_i);
      g_r[0] <= g_nxt;
      for (int k = 1; k < 7; k++) begin
        g_r[k] <= g_r[k-1];
      end
      r_r       <= HALF_Q48 - sqx_r - sqy_r;
      t1_r      <= r_r[63] ? 30'd0 : t1_rnd[29:0];
      p1_r      <= 60'(t1_r) * 60'(t1_r);
      t2_r      <= p1_rnd[28:0];
      p2_r      <= 58'(t2_r) * 58'(t2_r);
      t3_r      <= p2_rnd[26:0];
      p3_r      <= $signed({37'd0, t3_r}) * 64'(g_r[6]);
      contrib_r <= p3_rnd[SUM_W-1:0];
    end
  end

  assign vld_o     = vld_r[8];
  assign contrib_o = contrib_r;

endmodule

[src/sn2d_back.sv]
`timescale 1ns / 1ps
module sn2d_back
  import sn2d_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_vld,
  input  item_t              head,
  output logic               head_pop,
  output logic               empty,
  input  logic               pop,
  output logic [NOISE_W-1:0] noise_value
);

  localparam int K     = COORD_FRAC_BITS + 30;
  localparam int XS_SH = INT_FRAC - COORD_FRAC_BITS;

  logic en;

  // Stage control and load payload, stages 1..6
  logic [6:1]          vld_r, ld_r;
  logic [PERM_AW-1:0]  pidx_r [1:6];
  logic [PERM_DW-1:0]  pval_r [1:6];

  // Skew and unskew datapath
  logic signed [COORD_W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic signed [32:0]        s1_r;
  logic signed [63:0]        m2_r;
  logic signed [31:0]        i3_r, j3_r;
  logic signed [32:0]        ij4_r;
  logic signed [OFS_W-1:0]   ax4_r, ay4_r, ax5_r, ay5_r;
  logic [PERM_AW-1:0]        i4_r, j4_r, i5_r, i6_r;
  logic signed [63:0]        prod5_r;
  logic signed [OFS_W-1:0]   x0_6_r, y0_6_r;
  logic [PERM_DW-1:0]        pj0_6_r, pj1_6_r;
  logic                      ev7_r;
  logic signed [OFS_W-1:0]   ox0_r, oy0_r, ox1_r, oy1_r, ox2_r, oy2_r;

  logic signed [63:0] sx3, sy3, sx3_sh, sy3_sh, t6_rnd;
  logic signed [OFS_W-1:0] t6;
  logic               i1;
  logic [PERM_AW-1:0] addr_c, addr_d, addr_e;

  // Table copies: two for the row lookups, three for the corner hashes
  logic               we_ab, we_cde;
  logic [PERM_DW-1:0] pj0, pj1, hash0, hash1, hash2;

  // Accumulate and scale
  logic                    cvld, cvld1, cvld2;
  logic signed [SUM_W-1:0] c0, c1, c2;
  logic                    sum_vld_r, mul_vld_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [63:0]      mul_r;
  logic signed [63:0]      res_sh;
  logic [NOISE_W-1:0]      res;

  // Output queue
  logic [NOISE_W-1:0] oq_r [2];
  logic               oq_wr_r, oq_rd_r;
  logic [1:0]         oq_cnt_r, oq_cnt_nxt;
  logic               oq_full, oq_push, oq_pop;

  // Whole back pipeline moves when the output queue has room
  assign oq_full  = (oq_cnt_r == 2'd2);
  assign en       = !oq_full || pop;
  assign head_pop = en && head_vld;

  // Valid and kind line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ld_r      <= '0;
      ev7_r     <= 1'b0;
      sum_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[5:1], head_vld};
      ld_r      <= {ld_r[5:1], head.op == OP_LOAD};
      ev7_r     <= vld_r[6] && !ld_r[6];
      sum_vld_r <= cvld && cvld1 && cvld2;
      mul_vld_r <= sum_vld_r;
    end
  end

  // Combinational pieces of the skew stages
  always_comb begin
    sx3    = (64'(x2_r) <<< 30) + m2_r;
    sy3    = (64'(y2_r) <<< 30) + m2_r;
    sx3_sh = sx3 >>> K;
    sy3_sh = sy3 >>> K;
    t6_rnd = (prod5_r + 64'sd32) >>> 6;
    t6     = t6_rnd[OFS_W-1:0];
  end

  // Pick the middle corner and form the hash addresses
  always_comb begin
    i1     = (x0_6_r > y0_6_r);
    addr_c = i6_r + pj0_6_r;
    addr_d = i1 ? (i6_r + 8'd1 + pj0_6_r) : (i6_r + pj1_6_r);
    addr_e = i6_r + 8'd1 + pj1_6_r;
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      pidx_r[1] <= head.perm_index;
      pval_r[1] <= head.perm_value;
      for (int k = 2; k <= 6; k++) begin
        pidx_r[k] <= pidx_r[k-1];
        pval_r[k] <= pval_r[k-1];
      end
      // stage 1: x + y
      x1_r <= head.x_coord;
      y1_r <= head.y_coord;
      s1_r <= 33'(head.x_coord) + 33'(head.y_coord);
      // stage 2: (x + y) * F2
      x2_r <= x1_r;
      y2_r <= y1_r;
      m2_r <= 64'(s1_r) * F2_Q30;
      // stage 3: floor to cell
      x3_r <= x2_r;
      y3_r <= y2_r;
      i3_r <= sx3_sh[31:0];
      j3_r <= sy3_sh[31:0];
      // stage 4: cell sum and offset base
      ij4_r <= 33'(i3_r) + 33'(j3_r);
      ax4_r <= (x3_r <<< XS_SH) - (i3_r <<< INT_FRAC);
      ay4_r <= (y3_r <<< XS_SH) - (j3_r <<< INT_FRAC);
      i4_r  <= i3_r[PERM_AW-1:0];
      j4_r  <= j3_r[PERM_AW-1:0];
      // stage 5: unskew product
      prod5_r <= 64'(ij4_r) * G2_Q30;
      ax5_r   <= ax4_r;
      ay5_r   <= ay4_r;
      i5_r    <= i4_r;
      // stage 6: first corner offsets, row lookups
      x0_6_r  <= ax5_r + t6;
      y0_6_r  <= ay5_r + t6;
      i6_r    <= i5_r;
      pj0_6_r <= pj0;
      pj1_6_r <= pj1;
      // stage 7: all corner offsets
      ox0_r <= x0_6_r;
      oy0_r <= y0_6_r;
      ox1_r <= x0_6_r - (i1 ? ONE_Q24 : '0) + G2_Q24;
      oy1_r <= y0_6_r - (i1 ? '0 : ONE_Q24) + G2_Q24;
      ox2_r <= x0_6_r - ONE_Q24 + G2X2_Q24;
      oy2_r <= y0_6_r - ONE_Q24 + G2X2_Q24;
      // sum and scale
      sum_r <= c0 + c1 + c2;
      mul_r <= 64'(sum_r) * SCALE_Q20;
    end
  end

  // A load writes each copy at the stage where that copy is read
  assign we_ab  = en && vld_r[4] && ld_r[4];
  assign we_cde = en && vld_r[6] && ld_r[6];

  sn2d_ram #(.WIDTH(PERM_DW), .DEPTH(PERM_ENTRIES)) u_ram_a (
    .clk(clk), .we(we_ab), .waddr(pidx_r[4]), .wdata(pval_r[4]),
    .re(en), .raddr(j4_r), .rdata(pj0)
  );

  sn2d_ram #(.WIDTH(PERM_DW), .DEPTH(PERM_ENTRIES)) u_ram_b (
    .clk(clk), .we(we_ab), .waddr(pidx_r[4]), .wdata(pval_r[4]),
    .re(en), .raddr(j4_r + 8'd1), .rdata(pj1)
  );

  sn2d_ram #(.WIDTH(PERM_DW), .DEPTH(PERM_ENTRIES)) u_ram_c (
    .clk(clk), .we(we_cde), .waddr(pidx_r[6]), .wdata(pval_r[6]),
    .re(en), .raddr(addr_c), .rdata(hash0)
  );

  sn2d_ram #(.WIDTH(PERM_DW), .DEPTH(PERM_ENTRIES)) u_ram_d (
    .clk(clk), .we(we_cde), .waddr(pidx_r[6]), .wdata(pval_r[6]),
    .re(en), .raddr(addr_d), .rdata(hash1)
  );

  sn2d_ram #(.WIDTH(PERM_DW), .DEPTH(PERM_ENTRIES)) u_ram_e (
    .clk(clk), .we(we_cde), .waddr(pidx_r[6]), .wdata(pval_r[6]),
    .re(en), .raddr(addr_e), .rdata(hash2)
  );

  // Three corner units in lockstep
  sn2d_corner u_corner0 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ev7_r),
    .dx_i(ox0_r), .dy_i(oy0_r), .hash_i(hash0),
    .vld_o(cvld), .contrib_o(c0)
  );

  sn2d_corner u_corner1 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ev7_r),
    .dx_i(ox1_r), .dy_i(oy1_r), .hash_i(hash1),
    .vld_o(cvld1), .contrib_o(c1)
  );

  sn2d_corner u_corner2 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(ev7_r),
    .dx_i(ox2_r), .dy_i(oy2_r), .hash_i(hash2),
    .vld_o(cvld2), .contrib_o(c2)
  );

  // Map to [0,1], round and saturate
  always_comb begin
    res_sh = (mul_r + ONE_Q50 + 64'sd17179869184) >>> 35;
    if (res_sh[63]) begin
      res = '0;
    end else if (res_sh > 64'sd65535) begin
      res = NOISE_MAX;
    end else begin
      res = res_sh[NOISE_W-1:0];
    end
  end

  // Output queue
  assign oq_push    = en && mul_vld_r;
  assign oq_pop     = pop && !empty;
  assign oq_cnt_nxt = oq_cnt_r + 2'(oq_push) - 2'(oq_pop);
  assign empty      = (oq_cnt_r == 2'd0);
  assign noise_value = oq_r[oq_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_wr_r  <= oq_wr_r ^ oq_push;
      oq_rd_r  <= oq_rd_r ^ oq_pop;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

endmodule

[src/simplex_noise_2d.sv]
`timescale 1ns / 1ps
// 2-D simplex noise evaluator.
// Input queue: drive in_op and the payload with in_push; a beat is taken on
// a clock edge with in_push high and in_full low. in_op = 0 writes
// in_perm_value into permutation entry in_perm_index and gives no result;
// in_op = 1 evaluates noise at (in_x_coord, in_y_coord), signed fixed point.
// Load all table entries that a point will touch before evaluating it.
// Result queue: out_noise_value is valid while out_empty is low and is taken
// on an edge with out_pop high. Results come in input order.
// Throughput: one beat per cycle while out_pop keeps the result queue drained.
// From the accepting edge to out_empty going low, an evaluation passes the skew/unskew stages, the
// two chained table lookups (five table copies, one read port each) and the
// nine-stage corner falloff pipelines.
// When out_pop stays low the back pipeline freezes once its two-entry output
// queue fills; the two-entry input queue then fills and in_full rises.
// Synchronous reset empties both queues and the pipeline; the permutation
// table keeps no reset value and must be loaded again.
module simplex_noise_2d
  import sn2d_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_op,
  input  logic [PERM_AW-1:0]        in_perm_index,
  input  logic [PERM_DW-1:0]        in_perm_value,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [NOISE_W-1:0]        out_noise_value
);

  logic  q_vld;
  item_t q_item;
  logic  q_pop;

  // Accept and classify beats
  sn2d_front u_front (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .full(in_full),
    .op(in_op), .perm_index(in_perm_index), .perm_value(in_perm_value),
    .x_coord(in_x_coord), .y_coord(in_y_coord),
    .head_vld(q_vld), .head(q_item), .head_pop(q_pop)
  );

  // Table writes and noise evaluation
  sn2d_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .head_vld(q_vld), .head(q_item), .head_pop(q_pop),
    .empty(out_empty), .pop(out_pop), .noise_value(out_noise_value)
  );

`ifndef NO_ASSERTIONS
  // The back end never takes from an empty queue
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("back end popped an empty input queue");

  // A waiting item is not lost while the back end stalls
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (q_vld && !q_pop) |=> q_vld)
    else $error("queued item vanished without a pop");

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");
`endif

endmodule
